### rtl/core/vrc_pkg.sv
// Shared types and constants for the volume ray compositor.
package vrc_pkg;

   // Field layout of the request and response streams
   localparam int FIELD_BITS     = 8;
   localparam int CORNER_COUNT   = 8;
   localparam int REQ_DATA_BITS  = 88;
   localparam int RSP_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   // Register indexes on the csr write channel
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTENSITY_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_OFFSET        = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_SCALE         = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPACITY_CUTOFF      = 8'd3;

   // Register values after reset
   localparam logic [7:0]  RST_INTENSITY_THRESHOLD = 8'd70;
   localparam logic [7:0]  RST_COLOR_OFFSET        = 8'd150;
   localparam logic [15:0] RST_ALPHA_SCALE         = 16'd6554;
   localparam logic [15:0] RST_OPACITY_CUTOFF      = 16'd62259;

   // Accumulator limits: gray is Q8.8, alpha is Q0.16
   localparam logic [15:0] GRAY_SAT  = 16'd65280;
   localparam logic [15:0] ALPHA_SAT = 16'd65535;
   localparam logic [16:0] ONE_Q16   = 17'h10000;

   // Sample queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef struct packed {
      logic [7:0]  intensity_threshold;
      logic [7:0]  color_offset;
      logic [15:0] alpha_scale;
      logic [15:0] opacity_cutoff;
   } vrc_cfg_type;

   // One classified sample, ready for blending
   typedef struct packed {
      logic        contrib;
      logic [7:0]  gray;
      logic [15:0] a_src;
      logic        last;
   } vrc_sample_type;

   typedef struct packed {
      logic [7:0]  pixel_gray;
      logic [15:0] pixel_alpha;
      logic        early_stop;
   } vrc_result_type;

   typedef enum logic {
      BACK_LOAD,
      BACK_ACCUM
   } vrc_back_state_type;

endpackage

### rtl/core/vrc_front.sv
// Front end: trilinear interpolation and transfer function, four stages deep.
module vrc_front import vrc_pkg::*; #(
   parameter int VOXEL_BITS = 8,
   parameter int FRAC_BITS  = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vrc_cfg_type              cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [REQ_DATA_BITS-1:0] in_data,
   input  logic                     in_last,
   output logic                     out_valid,
   input  logic                     out_ready,
   output vrc_sample_type           out_sample
);

   localparam int VW = VOXEL_BITS;
   localparam int FW = FRAC_BITS;
   localparam int XW = VW + FW;
   localparam int YW = VW + 2 * FW;
   localparam int NW = VW + 16;
   localparam int RW = 18;
   localparam logic [VW-1:0] VOX_MAX   = '1;
   localparam logic [VW-1:0] VOX_HALF  = VOX_MAX >> 1;
   localparam logic [FW:0]   FRAC_ONE  = (FW+1)'(1) << FW;
   localparam logic [YW-1:0] FRAC_HALF = YW'(1) << (FW - 1);

   // a*(1-f) + b*f with f in units of 2^-FW
   function automatic logic [YW-1:0] lerp(input logic [XW-1:0] a, input logic [XW-1:0] b,
                                          input logic [FW-1:0] f);
      logic [FW:0] g;
      logic [YW:0] pa;
      logic [YW:0] pb;
      g  = FRAC_ONE - {1'b0, f};
      pa = (YW+1)'(a) * (YW+1)'(g);
      pb = (YW+1)'(b) * (YW+1)'(f);
      return YW'(pa + pb);
   endfunction

   // Drop FW fraction bits, rounding half up
   function automatic logic [XW-1:0] round_frac(input logic [YW-1:0] w);
      logic [YW-1:0] t;
      t = w + FRAC_HALF;
      return XW'(t >> FW);
   endfunction

   logic            adv;
   logic [XW-1:0]   corner [CORNER_COUNT];
   logic [FW-1:0]   fx;
   logic [FW-1:0]   fy;
   logic [FW-1:0]   fz;
   logic [XW-1:0]   s1_x_in [4];
   logic [XW-1:0]   s2_y_in [2];
   logic [YW-1:0]   s3_vz_in;
   logic [XW-1:0]   vr1;
   logic [XW-1:0]   vr2;
   logic [VW-1:0]   v;
   logic [7:0]      i8;
   logic [8:0]      gray_sum;
   logic [7:0]      s4_gray_in;
   logic            s4_contrib_in;
   logic [NW-1:0]   s4_n_in;
   logic [RW-1:0]   rem;
   logic [16:0]     quo;

   logic            s1_valid_ff;
   logic [XW-1:0]   s1_x_ff [4];
   logic [FW-1:0]   s1_fy_ff;
   logic [FW-1:0]   s1_fz_ff;
   logic            s1_last_ff;
   logic            s2_valid_ff;
   logic [XW-1:0]   s2_y_ff [2];
   logic [FW-1:0]   s2_fz_ff;
   logic            s2_last_ff;
   logic            s3_valid_ff;
   logic [YW-1:0]   s3_vz_ff;
   logic            s3_last_ff;
   logic            s4_valid_ff;
   logic [NW-1:0]   s4_n_ff;
   logic [7:0]      s4_gray_ff;
   logic            s4_contrib_ff;
   logic            s4_last_ff;

   // Advance the whole pipe unless the last stage is blocked
   assign adv      = !s4_valid_ff || out_ready;
   assign in_ready = adv;

   // Unpack the request and interpolate along x
   always_comb begin
      for (int i = 0; i < CORNER_COUNT; i++) begin
         corner[i] = XW'(in_data[FIELD_BITS*i +: FIELD_BITS]);
      end
      fx = FW'(in_data[FIELD_BITS*CORNER_COUNT +: FIELD_BITS]);
      fy = FW'(in_data[FIELD_BITS*(CORNER_COUNT+1) +: FIELD_BITS]);
      fz = FW'(in_data[FIELD_BITS*(CORNER_COUNT+2) +: FIELD_BITS]);
      for (int k = 0; k < 4; k++) begin
         s1_x_in[k] = XW'(lerp(corner[2*k], corner[2*k+1], fx));
      end
   end

   // Interpolate along y and z
   always_comb begin
      for (int j = 0; j < 2; j++) begin
         s2_y_in[j] = round_frac(lerp(s1_x_ff[2*j], s1_x_ff[2*j+1], s1_fy_ff));
      end
      s3_vz_in = lerp(s2_y_ff[0], s2_y_ff[1], s2_fz_ff);
   end

   // Round to an intensity, apply threshold and gray offset, form alpha numerator
   always_comb begin
      vr1 = round_frac(s3_vz_ff);
      vr2 = round_frac(YW'(vr1));
      v   = (vr2 > XW'(VOX_MAX)) ? VOX_MAX : VW'(vr2);
      i8  = 8'(v >> (VW - 8));
      gray_sum      = {1'b0, i8} + {1'b0, cfg.color_offset};
      s4_gray_in    = gray_sum[8] ? 8'hFF : gray_sum[7:0];
      s4_contrib_in = i8 > cfg.intensity_threshold;
      s4_n_in       = NW'(v) * NW'(cfg.alpha_scale) + NW'(VOX_HALF);
   end

   // Divide by 2^VW-1: fold the high part onto the low part, then correct once
   always_comb begin
      quo = 17'(s4_n_ff >> VW);
      rem = RW'(s4_n_ff >> VW) + RW'(s4_n_ff[VW-1:0]);
      for (int k = 0; k < 2; k++) begin
         quo = quo + 17'(rem >> VW);
         rem = RW'(rem >> VW) + RW'(rem[VW-1:0]);
      end
      if (rem >= RW'(VOX_MAX)) begin
         quo = quo + 17'd1;
      end
   end

   assign out_valid          = s4_valid_ff;
   assign out_sample.contrib = s4_contrib_ff;
   assign out_sample.gray    = s4_gray_ff;
   assign out_sample.a_src   = 16'(quo);
   assign out_sample.last    = s4_last_ff;

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff       <= s1_x_in;
         s1_fy_ff      <= fy;
         s1_fz_ff      <= fz;
         s1_last_ff    <= in_last;
         s2_y_ff       <= s2_y_in;
         s2_fz_ff      <= s1_fz_ff;
         s2_last_ff    <= s1_last_ff;
         s3_vz_ff      <= s3_vz_in;
         s3_last_ff    <= s2_last_ff;
         s4_n_ff       <= s4_n_in;
         s4_gray_ff    <= s4_gray_in;
         s4_contrib_ff <= s4_contrib_in;
         s4_last_ff    <= s3_last_ff;
      end
   end

endmodule

### rtl/core/vrc_queue.sv
// Small sample queue that decouples the front end from the blender.
module vrc_queue import vrc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  vrc_sample_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output vrc_sample_type pop_data
);

   vrc_sample_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]     count_ff;
   logic                        push;
   logic                        pop;

   assign push_ready = count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Store the pushed sample
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/vrc_back.sv
// Back end: front-to-back blend of one ray, early stop and result register.
module vrc_back import vrc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [15:0]    opacity_cutoff,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  vrc_sample_type pop_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output vrc_result_type rsp_data
);

   vrc_back_state_type state_ff;
   vrc_back_state_type state_in;
   vrc_sample_type     item_ff;
   vrc_sample_type     item_in;
   logic [32:0]        prod_ff;
   logic [32:0]        prod_in;
   logic [15:0]        accum_gray_ff;
   logic [15:0]        accum_gray_in;
   logic [15:0]        accum_alpha_ff;
   logic [15:0]        accum_alpha_in;
   logic               ray_finished_ff;
   logic               ray_finished_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   vrc_result_type     rsp_ff;
   vrc_result_type     rsp_in;

   logic [16:0]        one_minus;
   logic [16:0]        a_add;
   logic [40:0]        g_prod;
   logic [16:0]        g_add;
   logic [17:0]        gray_sum;
   logic [17:0]        alpha_sum;
   logic [15:0]        gray_new;
   logic [15:0]        alpha_new;
   logic               stop;
   logic               emit;
   logic               rsp_load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Blend arithmetic on the registered sample
   always_comb begin
      one_minus = ONE_Q16 - {1'b0, accum_alpha_ff};
      a_add     = 17'((prod_ff + 33'd32768) >> 16);
      g_prod    = 41'(item_ff.gray) * 41'(prod_ff);
      g_add     = 17'((g_prod + 41'd8388608) >> 24);
      gray_sum  = 18'(accum_gray_ff) + 18'(g_add);
      alpha_sum = 18'(accum_alpha_ff) + 18'(a_add);
      gray_new  = (gray_sum > 18'(GRAY_SAT)) ? GRAY_SAT : 16'(gray_sum);
      alpha_new = (alpha_sum > 18'(ALPHA_SAT)) ? ALPHA_SAT : 16'(alpha_sum);
      if (!item_ff.contrib) begin
         gray_new  = accum_gray_ff;
         alpha_new = accum_alpha_ff;
      end
      stop = alpha_new > opacity_cutoff;
      emit = stop || item_ff.last;
   end

   // Next state: take a sample (or drop it after an early stop), then accumulate and decide on a result
   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      prod_in         = prod_ff;
      accum_gray_in   = accum_gray_ff;
      accum_alpha_in  = accum_alpha_ff;
      ray_finished_in = ray_finished_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      rsp_load        = 1'b0;
      pop_ready       = 1'b0;
      case (state_ff)
         BACK_LOAD: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (ray_finished_ff) begin
                  // drop samples after an early stop until the ray ends
                  if (pop_data.last) begin
                     accum_gray_in   = '0;
                     accum_alpha_in  = '0;
                     ray_finished_in = 1'b0;
                  end
               end else begin
                  item_in  = pop_data;
                  prod_in  = 33'(one_minus) * 33'(pop_data.a_src);
                  state_in = BACK_ACCUM;
               end
            end
         end
         BACK_ACCUM: begin
            if (!(emit && rsp_valid_ff && !rsp_ready)) begin
               state_in = BACK_LOAD;
               if (emit) begin
                  rsp_load               = 1'b1;
                  rsp_valid_in           = 1'b1;
                  rsp_in.pixel_gray      = gray_new[15:8];
                  rsp_in.pixel_alpha     = alpha_new;
                  rsp_in.early_stop      = stop;
               end
               if (item_ff.last) begin
                  accum_gray_in   = '0;
                  accum_alpha_in  = '0;
                  ray_finished_in = 1'b0;
               end else begin
                  accum_gray_in   = gray_new;
                  accum_alpha_in  = alpha_new;
                  ray_finished_in = stop;
               end
            end
         end
         default: begin
            state_in = BACK_LOAD;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BACK_LOAD;
         accum_gray_ff   <= '0;
         accum_alpha_ff  <= '0;
         ray_finished_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         accum_gray_ff   <= accum_gray_in;
         accum_alpha_ff  <= accum_alpha_in;
         ray_finished_ff <= ray_finished_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTH
   // Gray never passes 255.0
   assert property (@(posedge clock) disable iff (reset) accum_gray_ff <= GRAY_SAT)
      else $error("accumulated gray above saturation");

   // A ray that stopped early never reaches the accumulate step
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == BACK_ACCUM |-> !ray_finished_ff)
      else $error("sample blended after early stop");

   // A result without early stop closes the ray and clears the accumulators
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_load && !stop) |=> (accum_gray_ff == '0 && accum_alpha_ff == '0))
      else $error("accumulators not cleared at end of ray");

   // A result is loaded only into a free or draining output register
   assert property (@(posedge clock) disable iff (reset)
                    rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
`endif

endmodule

### rtl/core/volume_ray_compositor.sv
// Top level of the volume ray compositor: csr registers, front end, queue, blender.
//
// Each request is one ray sample (eight corner voxels, three fractional offsets,
// tlast on the ray's final sample). A four-stage front end interpolates the
// sample trilinearly, applies the threshold transfer function and computes the
// source alpha; it accepts one request per cycle while the queue has room. A
// four-entry queue feeds the blender, which takes a sample in its load state and
// blends it in its accumulate state before it takes the next: the (1 - alpha) *
// source alpha product is registered before the gray product and the accumulate,
// and the next sample of the ray needs the updated alpha. Samples that follow an
// early stop are dropped at one per cycle. One response is sent per ray, at early
// stop or at the last sample; tuser marks the early stop. Write the csr registers
// only while no ray is in flight.
module volume_ray_compositor import vrc_pkg::*; #(
   parameter int VOXEL_BITS = 8,
   parameter int FRAC_BITS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // corner_000, corner_100, corner_010, corner_110, corner_001, corner_101,
   // corner_011, corner_111, frac_x, frac_y, frac_z (8 bits each)
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                      req_tlast,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pixel_gray (8 bits), pixel_alpha (16 bits)
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // early_stop
   output logic                      rsp_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   vrc_cfg_type    cfg_ff;
   vrc_cfg_type    cfg_in;
   logic           front_valid;
   logic           front_ready;
   vrc_sample_type front_sample;
   logic           queue_valid;
   logic           queue_ready;
   vrc_sample_type queue_sample;
   vrc_result_type rsp;

   assign csr_ready = 1'b1;

   // Decode csr writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INTENSITY_THRESHOLD: cfg_in.intensity_threshold = csr_wdata[7:0];
            CSR_COLOR_OFFSET:        cfg_in.color_offset        = csr_wdata[7:0];
            CSR_ALPHA_SCALE:         cfg_in.alpha_scale         = csr_wdata;
            CSR_OPACITY_CUTOFF:      cfg_in.opacity_cutoff      = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.intensity_threshold <= RST_INTENSITY_THRESHOLD;
         cfg_ff.color_offset        <= RST_COLOR_OFFSET;
         cfg_ff.alpha_scale         <= RST_ALPHA_SCALE;
         cfg_ff.opacity_cutoff      <= RST_OPACITY_CUTOFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vrc_front #(
      .VOXEL_BITS (VOXEL_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_last    (req_tlast),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_sample (front_sample)
   );

   vrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_sample),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_sample)
   );

   vrc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .opacity_cutoff (cfg_ff.opacity_cutoff),
      .pop_valid      (queue_valid),
      .pop_ready      (queue_ready),
      .pop_data       (queue_sample),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_data       (rsp)
   );

   // Pack the response
   assign rsp_tdata = {rsp.pixel_alpha, rsp.pixel_gray};
   assign rsp_tuser = rsp.early_stop;

endmodule
